// File: hdl/lanc_pkg.sv
package lanc_pkg;

    localparam int TAP_COUNT            = 10;
    localparam int WEIGHT_FRACTION_BITS = 30;
    localparam int STEP_FRACTION_BITS   = 56;
    localparam int UPDATE_SHIFT         = STEP_FRACTION_BITS - WEIGHT_FRACTION_BITS;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 32;
    localparam int STEP_W   = 24;
    localparam int MUL_B_W  = STEP_W + 1;
    localparam int PROD_W   = WEIGHT_W + MUL_B_W;
    localparam int IDX_W    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(72058);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(TAP_COUNT - 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [MUL_B_W-1:0]  mul_b_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic [IDX_W-1:0]           tap_idx_t;

    typedef struct packed {
        logic     shift;
        logic     wr_en;
        tap_idx_t idx;
    } tap_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIR,
        ST_DRAIN,
        ST_ERR,
        ST_UPD_A,
        ST_UPD_B,
        ST_UPD_W
    } lanc_state_t;

endpackage

// File: hdl/lanc_mult.sv
module lanc_mult
    import lanc_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  weight_t a,
    input  mul_b_t  b,
    output prod_t   prod
);

    prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// File: hdl/lanc_tap_store.sv
module lanc_tap_store
    import lanc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tap_ctl_t ctl,
    input  sample_t  ref_in,
    input  weight_t  w_wr_data,
    output weight_t  w_rd,
    output sample_t  x_rd
);

    weight_t w_reg [TAP_COUNT];
    sample_t x_reg [TAP_COUNT];

    // delay line, newest sample at tap 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                x_reg[i] <= '0;
            end
        end
        else if (ctl.shift)
        begin
            for (int i = TAP_COUNT - 1; i > 0; i--)
            begin
                x_reg[i] <= x_reg[i-1];
            end
            x_reg[0] <= ref_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TAP_COUNT; i++)
            begin
                w_reg[i] <= '0;
            end
        end
        else if (ctl.wr_en)
        begin
            w_reg[ctl.idx] <= w_wr_data;
        end
    end

    assign w_rd = w_reg[ctl.idx];
    assign x_rd = x_reg[ctl.idx];

endmodule

// File: hdl/lms_adaptive_noise_canceller_top.sv
// lms adaptive noise canceller
//
// input stream s_*: one request carries a reference noise sample and a primary
// sample (signal plus correlated noise). output stream m_*: one request per
// input with error = primary - fir estimate, saturated to 16 bits.
// cfg_wr_en / cfg_wr_data write the 24-bit lms step size; write only when idle.
//
// one shared 32x25 multiplier does all the work under a small sequencer:
// one fir product per tap plus a drain step, an error step that forms the
// error, then three steps per tap for the weight update (err*x, times step,
// write back). the result is loaded into the output register in the error
// step; a new input is taken only in idle, after the weight update of every
// tap, so the multiplier passes over the taps set the input rate.
//
// reset clears weights, delay line and the output register and loads the
// default step size. a stalled receiver holds the result in the output
// register; the block still takes the next input and waits in the error step
// until that register is free, so the input stalls after one more request.
module lms_adaptive_noise_canceller_top
    import lanc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,     // primary_sample, reference_sample
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,     // error_sample
    input  logic              cfg_wr_en,
    input  logic [STEP_W-1:0] cfg_wr_data
);

    localparam int ACC_W  = PROD_W;
    localparam int DIFF_W = ACC_W + 1;
    localparam int WS_W   = PROD_W + 1;

    lanc_state_t state_reg, state_next;
    tap_idx_t    idx_reg, idx_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    sample_t     primary_reg, primary_next;
    sample_t     err_reg, err_next;
    sample_t     out_data_reg, out_data_next;
    logic        out_vld_reg, out_vld_next;
    logic [STEP_W-1:0] step_reg;

    tap_ctl_t ctl;
    weight_t  w_rd, w_wr_data, mult_a;
    sample_t  x_rd;
    mul_b_t   mult_b;
    logic     mult_en;
    prod_t    prod;
    logic     accept;

    logic signed [ACC_W-1:0]  est;
    logic signed [DIFF_W-1:0] diff;
    prod_t                    upd;
    logic signed [WS_W-1:0]   wsum;

    assign accept = s_tvalid && s_tready;

    lanc_tap_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ref_in    (sample_t'(s_tdata[15:0])),
        .w_wr_data (w_wr_data),
        .w_rd      (w_rd),
        .x_rd      (x_rd)
    );

    lanc_mult u_mult (
        .clk  (clk),
        .en   (mult_en),
        .a    (mult_a),
        .b    (mult_b),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            step_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            out_vld_reg  <= 1'b0;
            out_data_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            out_vld_reg  <= out_vld_next;
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        primary_reg <= primary_next;
        err_reg     <= err_next;
    end

    // error and weight update arithmetic
    always_comb
    begin
        est  = acc_reg >>> WEIGHT_FRACTION_BITS;
        diff = DIFF_W'(primary_reg) - DIFF_W'(est);
        upd  = prod >>> UPDATE_SHIFT;
        wsum = WS_W'(w_rd) + WS_W'(upd);
        if (diff[DIFF_W-1:SAMPLE_W-1] != {(DIFF_W-SAMPLE_W+1){diff[DIFF_W-1]}})
        begin
            err_next = diff[DIFF_W-1] ? sample_t'(-32768) : sample_t'(32767);
        end
        else
        begin
            err_next = diff[SAMPLE_W-1:0];
        end
        if (wsum[WS_W-1:WEIGHT_W-1] != {(WS_W-WEIGHT_W+1){wsum[WS_W-1]}})
        begin
            w_wr_data = wsum[WS_W-1] ? {1'b1, {(WEIGHT_W-1){1'b0}}}
                                     : {1'b0, {(WEIGHT_W-1){1'b1}}};
        end
        else
        begin
            w_wr_data = wsum[WEIGHT_W-1:0];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        primary_next  = primary_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_data_next = out_data_reg;
        s_tready      = (state_reg == ST_IDLE);
        mult_en       = 1'b0;
        mult_a        = w_rd;
        mult_b        = MUL_B_W'(x_rd);
        ctl.shift     = accept;
        ctl.wr_en     = 1'b0;
        ctl.idx       = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    primary_next = sample_t'(s_tdata[31:16]);
                    acc_next     = '0;
                    idx_next     = '0;
                    state_next   = ST_FIR;
                end
            end
            ST_FIR:
            begin
                mult_en = 1'b1;
                if (idx_reg != '0)
                begin
                    acc_next = acc_reg + ACC_W'(prod);
                end
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                acc_next   = acc_reg + ACC_W'(prod);
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next  = 1'b1;
                    out_data_next = err_next;
                    state_next    = ST_UPD_A;
                end
            end
            ST_UPD_A:
            begin
                mult_en    = 1'b1;
                mult_a     = WEIGHT_W'(err_reg);
                state_next = ST_UPD_B;
            end
            ST_UPD_B:
            begin
                mult_en    = 1'b1;
                mult_a     = prod[WEIGHT_W-1:0];
                mult_b     = {1'b0, step_reg};
                state_next = ST_UPD_W;
            end
            ST_UPD_W:
            begin
                ctl.wr_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_UPD_A;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
